>>> hdl/stroke_reveal_pixel_compositor_top_macros.svh
// Assertion macros for the stroke reveal pixel compositor.
// Used by the top level only; no other dependencies.
`ifndef STROKE_REVEAL_PIXEL_COMPOSITOR_TOP_MACROS_SVH
`define STROKE_REVEAL_PIXEL_COMPOSITOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/srpc_pkg.sv
// Shared types, register codes and RGB565 helpers for the stroke reveal compositor.
// No dependencies.
package srpc_pkg;

    typedef enum logic [1:0] {
        REG_PAPER    = 2'd0,
        REG_INK      = 2'd1,
        REG_PROGRESS = 2'd2,
        REG_ENABLE   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] paper;
        logic [15:0] ink;
        logic [7:0]  progress;
        logic        enable;
    } t_cfg;

    // Load strobes for the four pipeline stages.
    typedef struct packed {
        logic ld_in;
        logic ld_cov;
        logic ld_mul;
        logic ld_out;
    } t_stage_ld;

    // Channels widened to 6 bits: [2] red, [1] green, [0] blue.
    typedef logic [2:0][5:0] t_rgb;

    function automatic t_rgb split565(input logic [15:0] color);
        t_rgb ch;
        ch[2] = {1'b0, color[15:11]};
        ch[1] = color[10:5];
        ch[0] = {1'b0, color[4:0]};
        return ch;
    endfunction

    function automatic logic [15:0] pack565(input t_rgb ch);
        return {ch[2][4:0], ch[1], ch[0][4:0]};
    endfunction

endpackage

>>> hdl/srpc_regs.sv
// APB configuration registers for the stroke reveal compositor.
// Depends on srpc_pkg.
module srpc_regs import srpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx   = t_reg_idx'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.paper    <= 16'hFFFF;
            r_cfg.ink      <= 16'h0000;
            r_cfg.progress <= 8'd0;
            r_cfg.enable   <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_PAPER:    r_cfg.paper    <= pwdata[15:0];
                REG_INK:      r_cfg.ink      <= pwdata[15:0];
                REG_PROGRESS: r_cfg.progress <= pwdata[7:0];
                REG_ENABLE:   r_cfg.enable   <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PAPER:    prdata = {16'd0, r_cfg.paper};
            REG_INK:      prdata = {16'd0, r_cfg.ink};
            REG_PROGRESS: prdata = {24'd0, r_cfg.progress};
            REG_ENABLE:   prdata = {31'd0, r_cfg.enable};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/srpc_cov.sv
// Input register and coverage stage: soft reveal ramp and max with base coverage.
// Depends on srpc_pkg.
module srpc_cov import srpc_pkg::*; #(
    parameter int SOFT_EDGE = 3
) (
    input  logic        i_clk,
    input  t_stage_ld   i_ld,
    input  logic [23:0] i_tdata,
    input  t_cfg        i_cfg,
    output logic [7:0]  o_cov
);

    // shown = stroke * k / Div, done as (stroke * k * Recip) >> RecipShift.
    // Exact while 4095 * Div < 2^RecipShift.
    localparam int Div        = SOFT_EDGE + 1;
    localparam int RecipShift = 17;
    localparam int Recip      = (2 ** RecipShift + Div - 1) / Div;
    localparam int KmW        = 21;
    localparam int ProdW      = KmW + 8;
    localparam logic [KmW-1:0] KM [16] = '{
        KmW'(0 * Recip),  KmW'(1 * Recip),  KmW'(2 * Recip),  KmW'(3 * Recip),
        KmW'(4 * Recip),  KmW'(5 * Recip),  KmW'(6 * Recip),  KmW'(7 * Recip),
        KmW'(8 * Recip),  KmW'(9 * Recip),  KmW'(10 * Recip), KmW'(11 * Recip),
        KmW'(12 * Recip), KmW'(13 * Recip), KmW'(14 * Recip), KmW'(15 * Recip)
    };

    logic [7:0]       r_base;
    logic [7:0]       r_stroke;
    logic [7:0]       r_pos;
    logic [7:0]       r_cov;
    logic [7:0]       gap;
    logic             ahead;
    logic             in_ramp;
    logic [4:0]       k_full;
    logic [ProdW-1:0] prod;
    logic [7:0]       shown;
    logic [7:0]       n_cov;

    always_ff @(posedge i_clk) begin
        if (i_ld.ld_in) begin
            r_base   <= i_tdata[7:0];
            r_stroke <= i_tdata[15:8];
            r_pos    <= i_tdata[23:16];
        end
        if (i_ld.ld_cov) begin
            r_cov <= n_cov;
        end
    end

    always_comb begin
        gap     = r_pos - i_cfg.progress;
        ahead   = r_pos > i_cfg.progress;
        in_ramp = ahead && (gap <= 8'(SOFT_EDGE));
        k_full  = 5'(SOFT_EDGE + 1) - gap[4:0];
        prod    = ProdW'(r_stroke) * ProdW'(KM[k_full[3:0]]);
        if (!i_cfg.enable || r_stroke == 8'd0) begin
            shown = 8'd0;
        end else if (!ahead) begin
            shown = r_stroke;
        end else if (in_ramp) begin
            shown = prod[RecipShift +: 8];
        end else begin
            shown = 8'd0;
        end
        n_cov = (r_base > shown) ? r_base : shown;
    end

    assign o_cov = r_cov;

endmodule

>>> hdl/srpc_blend.sv
// Blend stages: per-channel scaled difference, then /255 moves paper toward ink.
// Depends on srpc_pkg.
module srpc_blend import srpc_pkg::*; (
    input  logic        i_clk,
    input  t_stage_ld   i_ld,
    input  logic [7:0]  i_cov,
    input  t_cfg        i_cfg,
    output logic [15:0] o_color
);

    // q = floor(m / 255) as (m * Recip255) >> 22, exact for m < 16384.
    localparam int Shift255 = 22;
    localparam int Recip255 = (2 ** Shift255 + 254) / 255;
    localparam int MulW     = 29;

    logic [2:0][13:0] r_mag;
    logic [2:0]       r_neg;
    logic [15:0]      r_color;
    t_rgb             from_c;
    t_rgb             to_c;
    logic [2:0][13:0] n_mag;
    logic [2:0]       n_neg;
    logic [2:0][MulW-1:0] q_prod;
    t_rgb             n_ch;

    always_comb begin
        from_c = split565(i_cfg.paper);
        to_c   = split565(i_cfg.ink);
        for (int c = 0; c < 3; c++) begin
            n_neg[c] = to_c[c] < from_c[c];
            n_mag[c] = n_neg[c] ? 14'(from_c[c] - to_c[c]) * 14'(i_cov)
                                : 14'(to_c[c] - from_c[c]) * 14'(i_cov);
            q_prod[c] = MulW'(r_mag[c]) * MulW'(Recip255);
            n_ch[c]   = r_neg[c] ? from_c[c] - q_prod[c][Shift255 +: 6]
                                 : from_c[c] + q_prod[c][Shift255 +: 6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld_mul) begin
            r_mag <= n_mag;
            r_neg <= n_neg;
        end
        if (i_ld.ld_out) begin
            r_color <= pack565(n_ch);
        end
    end

    assign o_color = r_color;

endmodule

>>> hdl/stroke_reveal_pixel_compositor_top.sv
// Channel  | Dir | Handshake                   | Payload
// ---------+-----+-----------------------------+------------------------------------------
// s (in)   | in  | i_s_tvalid / o_s_tready     | i_s_tdata: base, stroke, reveal position
// m (out)  | out | o_m_tvalid / i_m_tready     | o_m_tdata: RGB565 pixel color
// apb cfg  | in  | psel, penable, pwrite,pready| paddr, pwdata, prdata
//
// One pixel per clock while i_m_tready is high; o_m_tvalid is the result register's valid.
// Stages: input register, coverage register (one 8x21 multiply), scaled difference
// register (three 6x8 multiplies), result register (three reciprocal multiplies).
// Each stage carries its own valid bit and loads when empty or when the next one
// moves, so input is taken while a result waits, until all four stages are full.
// Reset (synchronous, active low) clears the valid bits and the config registers.
// Top level: depends on srpc_pkg, srpc_regs, srpc_cov, srpc_blend and the macro header.
`include "stroke_reveal_pixel_compositor_top_macros.svh"

module stroke_reveal_pixel_compositor_top import srpc_pkg::*; #(
    parameter int SOFT_EDGE = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] base_coverage, [15:8] stroke_coverage,
                                     // [23:16] reveal_position
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] pixel_color
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      cfg;
    t_stage_ld ld;

    // Valid bit per stage; r_v_out drives o_m_tvalid.
    logic r_v_in;
    logic r_v_cov;
    logic r_v_mul;
    logic r_v_out;

    // A stage may load when it is empty or its content moves on this cycle.
    logic rdy_in;
    logic rdy_cov;
    logic rdy_mul;
    logic rdy_out;

    assign pready = 1'b1;

    assign rdy_out = !r_v_out || i_m_tready;
    assign rdy_mul = !r_v_mul || rdy_out;
    assign rdy_cov = !r_v_cov || rdy_mul;
    assign rdy_in  = !r_v_in  || rdy_cov;

    assign o_s_tready = rdy_in;
    assign o_m_tvalid = r_v_out;

    // Payload registers advance with their stage; bubbles carry don't-care data.
    assign ld.ld_in  = i_s_tvalid && rdy_in;
    assign ld.ld_cov = rdy_cov;
    assign ld.ld_mul = rdy_mul;
    assign ld.ld_out = rdy_out;

    // Advance the valid bits alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in  <= 1'b0;
            r_v_cov <= 1'b0;
            r_v_mul <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (rdy_in) begin
                r_v_in <= i_s_tvalid;
            end
            if (rdy_cov) begin
                r_v_cov <= r_v_in;
            end
            if (rdy_mul) begin
                r_v_mul <= r_v_cov;
            end
            if (rdy_out) begin
                r_v_out <= r_v_mul;
            end
        end
    end

    srpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    logic [7:0] cov;

    // Soft reveal ramp and coverage select.
    srpc_cov #(
        .SOFT_EDGE (SOFT_EDGE)
    ) u_cov (
        .i_clk   (i_clk),
        .i_ld    (ld),
        .i_tdata (i_s_tdata),
        .i_cfg   (cfg),
        .o_cov   (cov)
    );

    // Paper-to-ink blend in RGB565.
    srpc_blend u_blend (
        .i_clk   (i_clk),
        .i_ld    (ld),
        .i_cov   (cov),
        .i_cfg   (cfg),
        .o_color (o_m_tdata)
    );

    // A transaction on the slave side must land in the input stage.
    `SRPC_ASSERT_NEXT(a_accept_fills_in, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_v_in, "accepted transaction lost at input stage")
    // With every stage full and the output stalled, input must be held off.
    `SRPC_ASSERT_NOW(a_full_stalls_in, i_clk, i_rst_n, r_v_in && r_v_cov && r_v_mul && r_v_out && !i_m_tready, !o_s_tready, "input accepted with full pipeline")
    // A product that moves on must show up as a result.
    `SRPC_ASSERT_NEXT(a_mul_reaches_out, i_clk, i_rst_n, r_v_mul && rdy_out, o_m_tvalid, "result lost between blend stages")
    // The enable register follows a write to its address.
    `SRPC_ASSERT_NEXT(a_enable_write, i_clk, i_rst_n, psel && penable && pwrite && paddr[3:2] == REG_ENABLE, cfg.enable == $past(pwdata[0]), "stroke enable write not taken")

endmodule

>>> verif/testbench.sv
// Self-checking testbench for stroke_reveal_pixel_compositor_top: random stream traffic
// with idling on both sides, APB register setup between phases, per-pixel prediction.
// Depends on srpc_pkg and the compositor RTL.
`timescale 1ns / 100ps

module testbench;
    import srpc_pkg::*;

    localparam int SOFT_EDGE      = 3;
    localparam int STALL_LIMIT    = 2000;  // cycles with no transaction anywhere
    localparam int DRAIN_CYCLES   = 16;    // comfortably past the four-stage latency
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_PIXELS   = 125;

    // One input pixel, laid out as it sits on i_s_tdata (base in the low byte).
    typedef struct packed {
        logic [7:0] reveal;
        logic [7:0] stroke;
        logic [7:0] base;
    } pixel_in_t;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    // Block inputs, all known from time zero
    logic        i_s_tvalid = 1'b0;
    logic [23:0] i_s_tdata  = '0;
    logic        i_m_tready = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;

    // Block outputs
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic [31:0] prdata;
    logic        pready;

    stroke_reveal_pixel_compositor_top #(
        .SOFT_EDGE (SOFT_EDGE)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow copy of the compositor registers, updated on each APB write edge.
    // Starts at the reset values: white paper, black ink, no progress, stroke off.
    t_cfg cfg = '{paper: 16'hFFFF, ink: 16'h0000, progress: 8'd0, enable: 1'b0};

    pixel_in_t   pending_pixels[$];   // pixels waiting to be offered on the slave side
    logic [15:0] expected_colors[$];  // predicted colors, oldest first
    int          pixels_issued   = 0;
    int          pixels_accepted = 0;
    int          mismatches      = 0;
    int          stall_cycles    = 0;
    logic        steady          = 1'b0;  // suppress idling on both sides

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Move one channel from paper toward ink by cov/255, truncating toward zero.
    function automatic int mix_channel(input int from, input int to, input int cov);
        return from + ((to - from) * cov) / 255;
    endfunction

    // Composite color for one pixel under the current register shadow.
    function automatic logic [15:0] composite_color(input pixel_in_t px);
        int gap;
        int shown;
        int cov;
        int red;
        int green;
        int blue;
        shown = 0;
        // The stroke plane contributes only while animating and where it has coverage.
        if (cfg.enable && px.stroke != 8'd0) begin
            gap = int'(cfg.progress) - int'(px.reveal);
            if (gap >= 0) begin
                // progress has passed this pixel: full stroke coverage
                shown = int'(px.stroke);
            end else if (gap >= -SOFT_EDGE) begin
                // inside the soft edge: linear ramp down ahead of the progress point
                shown = (int'(px.stroke) * (SOFT_EDGE + 1 + gap)) / (SOFT_EDGE + 1);
            end
        end
        cov   = (int'(px.base) > shown) ? int'(px.base) : shown;
        red   = mix_channel(int'(cfg.paper[15:11]), int'(cfg.ink[15:11]), cov);
        green = mix_channel(int'(cfg.paper[10:5]),  int'(cfg.ink[10:5]),  cov);
        blue  = mix_channel(int'(cfg.paper[4:0]),   int'(cfg.ink[4:0]),   cov);
        return {red[4:0], green[5:0], blue[4:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] MISMATCH %s: got 0x%04h, expected 0x%04h", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Slave-side driver: offer the next pending pixel, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
        end else begin
            // A transaction completes at this edge: record what the block must return.
            if (i_s_tvalid && o_s_tready) begin
                expected_colors.push_back(composite_color(pixel_in_t'(i_s_tdata)));
                pixels_accepted++;
            end
            // Advance only when the current pixel is gone or none is on offer;
            // otherwise hold tvalid and tdata stable.
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_pixels.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_pixels.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Master-side monitor: random backpressure, compare each pixel in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 33);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch("pixel_color with no pixel outstanding", o_m_tdata, 16'h0000);
            end else begin
                if (o_m_tdata !== expected_colors[0]) begin
                    report_mismatch("pixel_color", o_m_tdata, expected_colors[0]);
                end
                void'(expected_colors.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transaction on either stream or the APB port counts as progress
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                     || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("** stroke_reveal_pixel_compositor_top: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Register access and sequencing helpers
    // ------------------------------------------------------------------

    // APB write: setup cycle, then access cycle; the register loads at the edge
    // that ends the access cycle. Random upper bits check that only the low
    // bits of each register are kept.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_PAPER:    cfg.paper    = value[15:0];
            REG_INK:      cfg.ink      = value[15:0];
            REG_PROGRESS: cfg.progress = value[7:0];
            REG_ENABLE:   cfg.enable   = value[0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] paper, input logic [15:0] ink,
                              input logic [7:0] progress, input logic enable);
        write_reg(REG_PAPER,    ($urandom & 32'hFFFF_0000) | 32'(paper));
        write_reg(REG_INK,      ($urandom & 32'hFFFF_0000) | 32'(ink));
        write_reg(REG_PROGRESS, ($urandom & 32'hFFFF_FF00) | 32'(progress));
        write_reg(REG_ENABLE,   ($urandom & 32'hFFFF_FFFE) | 32'(enable));
    endtask

    task automatic queue_pixel(input logic [7:0] base, input logic [7:0] stroke,
                               input logic [7:0] reveal);
        pending_pixels.push_back('{reveal: reveal, stroke: stroke, base: base});
        pixels_issued++;
    endtask

    // Block until every queued pixel has been taken and every color returned,
    // then let the pipeline settle before touching registers.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pixels_accepted != pixels_issued || expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_color();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random pixel, weighted so that half the pixels land around the progress
    // point where the soft-edge ramp lives; the rest are unconstrained.
    task automatic queue_random_pixel();
        logic [7:0] base;
        logic [7:0] stroke;
        logic [7:0] reveal;
        if ($urandom_range(1))
            reveal = 8'(int'(cfg.progress) + int'($urandom_range(10)) - 5);
        else
            reveal = 8'($urandom);
        case ($urandom_range(9))
            0:       stroke = 8'd0;
            1:       stroke = 8'hFF;
            default: stroke = 8'($urandom);
        endcase
        // Keep base low most of the time so the stroke plane usually decides.
        case ($urandom_range(9))
            0:          base = 8'd0;
            1:          base = 8'hFF;
            2, 3, 4:    base = 8'($urandom);
            default:    base = 8'($urandom_range(48));
        endcase
        queue_pixel(base, stroke, reveal);
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        int n;
        logic [7:0] progress;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: stroke off, so only base coverage blends white toward black.
        queue_pixel(8'd0,   8'hFF, 8'd0);
        queue_pixel(8'hFF,  8'd0,  8'hFF);
        queue_pixel(8'd128, 8'hFF, 8'd0);
        queue_pixel(8'd1,   8'd200, 8'd77);
        wait_drained();

        // Stroke on at progress 100: walk the reveal position across the
        // soft edge, from well behind the progress point to past its far end.
        set_config(16'h0000, 16'hFFFF, 8'd100, 1'b1);
        for (n = 96; n <= 105; n++)
            queue_pixel(8'd0, 8'hFF, 8'(n));
        queue_pixel(8'd40,  8'd0,   8'd90);   // zero stroke coverage contributes nothing
        queue_pixel(8'd220, 8'd200, 8'd101);  // base outweighs the ramped stroke
        queue_pixel(8'd0,   8'd1,   8'd103);  // ramp truncates to zero
        queue_pixel(8'd0,   8'd7,   8'd102);
        wait_drained();

        // Opposite channel directions, progress at both ends of its range.
        set_config(16'hF81F, 16'h07E0, 8'd255, 1'b1);
        queue_pixel(8'd0, 8'hFF, 8'd0);
        queue_pixel(8'd0, 8'hFF, 8'hFF);
        queue_pixel(8'd0, 8'd129, 8'd254);
        wait_drained();
        set_config(16'h07E0, 16'hF81F, 8'd0, 1'b1);
        queue_pixel(8'd0, 8'hFF, 8'hFF);
        queue_pixel(8'd0, 8'hFF, 8'd0);
        queue_pixel(8'd3, 8'd90, 8'd2);
        wait_drained();

        // Random phases, each under a fresh register setting; progress hits
        // both extremes in the first two, and one phase runs without idling.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       progress = 8'd0;
                1:       progress = 8'hFF;
                default: progress = 8'($urandom);
            endcase
            set_config(pick_color(), pick_color(), progress,
                       (phase == 2) ? 1'b0 : ($urandom_range(4) != 0));
            steady <= (phase == 4);
            for (n = 0; n < PHASE_PIXELS; n++)
                queue_random_pixel();
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("** stroke_reveal_pixel_compositor_top: PASSED **");
        end else begin
            $display("** stroke_reveal_pixel_compositor_top: FAILED **");
        end
        $finish;
    end

endmodule
